>>> src/vhfm_pkg.sv
// shared types and constants for the variance health failsafe monitor
package vhfm_pkg;

    localparam int unsigned VAR_W   = 16;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [VAR_W-1:0]  THRESHOLD_RST = 16'd204;
    localparam logic [CNT_W-1:0]  FAIL_LIMIT_RST = 6'd10;
    localparam logic [TIME_W-1:0] WARN_INTERVAL_RST = 32'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD     = 2'd0,
        CFG_FAIL_LIMIT    = 2'd1,
        CFG_WARN_INTERVAL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              origin_valid;
        logic              var_valid;
        logic [VAR_W-1:0]  pos_variance;
        logic [VAR_W-1:0]  vel_variance;
        logic [VAR_W-1:0]  mag_variance_x;
        logic [VAR_W-1:0]  mag_variance_y;
        logic [VAR_W-1:0]  mag_variance_z;
        logic              flow_healthy;
        logic              pos_available;
        logic [TIME_W-1:0] now_ms;
    } tick_t;

    typedef struct packed {
        logic health_bad;
        logic yaw_reset_request;
        logic lane_switch_request;
        logic failsafe_trigger;
        logic failsafe_cleared;
        logic warning_send;
    } result_t;

endpackage

>>> src/vhfm_if.sv
// valid/ready channel interfaces for ticks and results
interface vhfm_tick_if
    import vhfm_pkg::*;
();
    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vhfm_result_if
    import vhfm_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/variance_health_failsafe_monitor.sv
// variance health failsafe monitor: vote, fail counter and failsafe pulses
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------
//  tick     | in  | valid/ready   | origin, variances, flags, now_ms
//  result   | out | valid/ready   | health_bad and five request pulses
//  cfg      | in  | write enable  | threshold, fail limit, warn interval
//
// a request is registered, then scored against the state and registered out:
// one request per cycle sustained while the result is not stalled
// the state update and the result register advance together, so each
// request is scored against the state left by the one before it
// reset clears the state, the pipeline valids and loads the default config
// a stalled result holds both stages; tick.ready drops only when both are full
module variance_health_failsafe_monitor
    import vhfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    vhfm_tick_if.sink            tick,
    vhfm_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [VAR_W-1:0]  threshold_reg;
    logic [CNT_W-1:0]  fail_limit_reg;
    logic [TIME_W-1:0] warn_interval_reg;

    logic [CNT_W-1:0]  fail_counter_reg, fail_counter_next;
    logic              bad_flag_reg, bad_flag_next;
    logic              ever_passed_reg, ever_passed_next;
    logic              failsafe_active_reg, failsafe_active_next;
    logic [TIME_W-1:0] last_warn_ms_reg, last_warn_ms_next;

    logic    s1_valid_reg;
    tick_t   s1_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg, out_data_next;

    logic advance;
    logic tick_ready;

    logic [VAR_W-1:0]  mag_xy;
    logic [VAR_W-1:0]  mag_max;
    logic [VAR_W:0]    th_double;
    logic              mag_vote;
    logic              vel_double;
    logic              vel_single;
    logic [1:0]        votes;
    logic              over;
    logic              passed;
    logic              ever_now;
    logic [CNT_W:0]    cnt_inc;
    logic [CNT_W:0]    limit_ext;
    logic [TIME_W-1:0] since_warn;

    assign advance    = !out_valid_reg || result.ready;
    assign tick_ready = !s1_valid_reg || advance;

    assign tick.ready   = tick_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // variance vote
    always_comb
    begin
        mag_xy     = (s1_data_reg.mag_variance_y > s1_data_reg.mag_variance_x)
                     ? s1_data_reg.mag_variance_y : s1_data_reg.mag_variance_x;
        mag_max    = (s1_data_reg.mag_variance_z > mag_xy)
                     ? s1_data_reg.mag_variance_z : mag_xy;
        th_double  = {threshold_reg, 1'b0};
        mag_vote   = mag_max >= threshold_reg;
        vel_double = !s1_data_reg.flow_healthy
                     && ({1'b0, s1_data_reg.vel_variance} >= th_double);
        vel_single = s1_data_reg.vel_variance >= threshold_reg;
        votes      = {1'b0, mag_vote}
                     + (vel_double ? 2'd2 : (vel_single ? 2'd1 : 2'd0));
        over       = s1_data_reg.var_valid && (threshold_reg != '0)
                     && (((s1_data_reg.pos_variance >= threshold_reg) && (votes != 2'd0))
                         || (votes >= 2'd2));
        passed     = !over && s1_data_reg.pos_available;
        ever_now   = ever_passed_reg || passed;
        cnt_inc    = {1'b0, fail_counter_reg} + {{CNT_W{1'b0}}, 1'b1};
        limit_ext  = {1'b0, fail_limit_reg};
        since_warn = s1_data_reg.now_ms - last_warn_ms_reg;
    end

    // state update and result
    always_comb
    begin
        fail_counter_next    = fail_counter_reg;
        bad_flag_next        = bad_flag_reg;
        ever_passed_next     = ever_passed_reg;
        failsafe_active_next = failsafe_active_reg;
        last_warn_ms_next    = last_warn_ms_reg;
        out_data_next        = '0;

        if (!s1_data_reg.origin_valid)
        begin
            // tick ignored
        end
        else if (threshold_reg == '0)
        begin
            fail_counter_next = '0;
            bad_flag_next     = 1'b0;
            if (failsafe_active_reg)
            begin
                failsafe_active_next           = 1'b0;
                out_data_next.failsafe_cleared = 1'b1;
            end
        end
        else
        begin
            ever_passed_next = ever_now;
            if (ever_now)
            begin
                if (!passed)
                begin
                    if (!bad_flag_reg)
                    begin
                        out_data_next.yaw_reset_request = (fail_limit_reg >= CNT_W'(2))
                            && (cnt_inc == limit_ext - (CNT_W+1)'(2)) && over;
                        out_data_next.lane_switch_request = (fail_limit_reg != '0)
                            && (cnt_inc == limit_ext - (CNT_W+1)'(1));
                        fail_counter_next = cnt_inc[CNT_W-1:0];
                        if (cnt_inc >= limit_ext)
                        begin
                            fail_counter_next              = fail_limit_reg;
                            bad_flag_next                  = 1'b1;
                            failsafe_active_next           = 1'b1;
                            out_data_next.failsafe_trigger = 1'b1;
                            if (since_warn > warn_interval_reg)
                            begin
                                out_data_next.warning_send = 1'b1;
                                last_warn_ms_next          = s1_data_reg.now_ms;
                            end
                        end
                    end
                end
                else if (fail_counter_reg != '0)
                begin
                    fail_counter_next = fail_counter_reg - CNT_W'(1);
                    // leaving failure once the counter drains
                    if (bad_flag_reg && (fail_counter_reg == CNT_W'(1)))
                    begin
                        bad_flag_next = 1'b0;
                        if (failsafe_active_reg)
                        begin
                            failsafe_active_next           = 1'b0;
                            out_data_next.failsafe_cleared = 1'b1;
                        end
                    end
                end
            end
        end

        out_data_next.health_bad = bad_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg       <= THRESHOLD_RST;
            fail_limit_reg      <= FAIL_LIMIT_RST;
            warn_interval_reg   <= WARN_INTERVAL_RST;
            fail_counter_reg    <= '0;
            bad_flag_reg        <= 1'b0;
            ever_passed_reg     <= 1'b0;
            failsafe_active_reg <= 1'b0;
            last_warn_ms_reg    <= '0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD:     threshold_reg     <= cfg_data[VAR_W-1:0];
                    CFG_FAIL_LIMIT:    fail_limit_reg    <= cfg_data[CNT_W-1:0];
                    CFG_WARN_INTERVAL: warn_interval_reg <= cfg_data[TIME_W-1:0];
                    default:           ;
                endcase
            end
            if (tick_ready)
            begin
                s1_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    fail_counter_reg    <= fail_counter_next;
                    bad_flag_reg        <= bad_flag_next;
                    ever_passed_reg     <= ever_passed_next;
                    failsafe_active_reg <= failsafe_active_next;
                    last_warn_ms_reg    <= last_warn_ms_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_ready && tick.valid)
        begin
            s1_data_reg <= tick.data;
        end
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> src/vhfm_checker.sv
// port-level checks for the variance health failsafe monitor
module vhfm_checker
    import vhfm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_data
);

    // a failure declaration always shows as bad in the same result
    a_trigger_bad: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.failsafe_trigger |-> res_data.health_bad)
        else $error("failsafe trigger without health_bad");

    // clearing only happens once the failure is gone
    a_clear_good: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.failsafe_cleared |-> !res_data.health_bad)
        else $error("failsafe cleared while health_bad");

    // warnings only come with a new failure declaration
    a_warn_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.warning_send |-> res_data.failsafe_trigger)
        else $error("warning without failsafe trigger");

    // yaw and lane requests sit at different counter values
    a_yaw_lane: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.yaw_reset_request && res_data.lane_switch_request))
        else $error("yaw and lane request together");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

endmodule

bind variance_health_failsafe_monitor vhfm_checker u_vhfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
